@@ hdl/bbid_pkg.sv @@
// Package for the balanced bootstrap index drawer.
// Holds sizes, codes, the sequencer state type and the transaction structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbid_pkg;

  // Storage sizes.
  localparam int MAX_SAMPLES = 1024;
  localparam int COUNT_BITS  = 31;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int N_W         = IDX_W + 1;
  localparam int TOTAL_W     = COUNT_BITS + IDX_W;

  // Field widths of the transactions and registers.
  localparam int NBOOT_W  = 20;
  localparam int WEIGHT_W = 31;
  localparam int RAND_W   = 64;
  localparam int CFG_W    = 20;

  // Shared multiplier: RAND_W by TOTAL_W bits.
  localparam int MUL_B_W   = TOTAL_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);
  localparam int MUL_P_W   = RAND_W + MUL_B_W;

  // Commands.
  localparam logic [1:0] ACT_START_UNIFORM = 2'd0;
  localparam logic [1:0] ACT_START_EMPTY   = 2'd1;
  localparam logic [1:0] ACT_WRITE_WEIGHT  = 2'd2;
  localparam logic [1:0] ACT_DRAW          = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_SAMPLE   = 2'd0;
  localparam logic [1:0] STAT_ACK      = 2'd1;
  localparam logic [1:0] STAT_MISMATCH = 2'd2;
  localparam logic [1:0] STAT_COMPLETE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SAMPLE_COUNT   = 2'd0;
  localparam logic [1:0] REG_RESAMPLE_COUNT = 2'd1;
  localparam logic [1:0] REG_LEAVE_ONE_OUT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EXP_MUL,
    ST_WR_READ,
    ST_WR_UPD,
    ST_OMIT_SEL,
    ST_OMIT_MUL,
    ST_OMIT_RD,
    ST_OMIT_WR,
    ST_COLLAPSE,
    ST_DRAW_GO,
    ST_DRAW_MUL,
    ST_SCAN,
    ST_DEC,
    ST_FINISH
  } bbid_state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [IDX_W-1:0]    index;
    logic [WEIGHT_W-1:0] weight;
    logic [RAND_W-1:0]   rand_draw;
    logic [RAND_W-1:0]   rand_omit;
  } bbid_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [N_W-1:0]     sample_index;
    logic [NBOOT_W-1:0] column_number;
    logic [IDX_W-1:0]   row_number;
    logic               last_in_column;
    logic               last_of_run;
  } bbid_out_t;

  // Handshake between the sequencer and the shared multiplier.
  typedef struct packed {
    logic               go;
    logic [RAND_W-1:0]  a;
    logic [MUL_B_W-1:0] b;
  } bbid_mul_req_t;

endpackage

`default_nettype wire

@@ hdl/bbid_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/bbid_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on bbid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbid_mul
  import bbid_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bbid_mul_req_t req,
  output logic               done,
  output logic [MUL_P_W-1:0] product
);

  logic [RAND_W-1:0]    a_q;
  logic [MUL_B_W-1:0]   b_q;
  logic [MUL_CNT_W-1:0] bit_cnt;
  logic                 running;

  // Control: a request loads the operands and runs MUL_B_W steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        running <= 1'b1;
      end else if (running && bit_cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // Datapath: one shift and one wide add per cycle.
  always_ff @(posedge clk) begin
    if (req.go) begin
      a_q     <= req.a;
      b_q     <= req.b;
      bit_cnt <= MUL_CNT_W'(MUL_B_W - 1);
      product <= '0;
    end else if (running) begin
      product <= {product[MUL_P_W-2:0], 1'b0}
               + (b_q[bit_cnt] ? {{MUL_B_W{1'b0}}, a_q} : '0);
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/balanced_bootstrap_index_drawer.sv @@
// Top level of the balanced bootstrap index drawer: sequencer and count store.
// Depends on bbid_pkg, bbid_ram and bbid_mul.
//
//  channel   signals                       direction  handshake
//  command   start, busy, cmd              in         start && !busy
//  result    done, result                  out        done, one cycle
//  config    cfg_we, cfg_index, cfg_data   in         cfg_we, any cycle
//
// A start command sweeps n counts, one per cycle, then waits for the shared
// multiplier (41 steps) to form n * nboot. A weight write that lands reads the old
// count, then writes the new one. With leave-one-out a draw at a column start
// picks the omitted index by rotation, or in the last round by a multiply on a
// random value; the draw takes another, and the scan reads up to n counts, one
// RAM read per cycle. Others answer at once; else done rises as busy falls.
// Reset is synchronous; the count RAM is not cleared, every entry below n is
// written at run start. The receiver cannot stall: a result shows for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module balanced_bootstrap_index_drawer
  import bbid_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire bbid_in_t         cmd,
  output logic                  done,
  output bbid_out_t             result,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  bbid_state_t st, st_next;

  // Configuration registers.
  logic [N_W-1:0]     sample_count;
  logic [NBOOT_W-1:0] resample_count;
  logic               leave_one_out;

  // Run state.
  logic [N_W-1:0]        run_n;
  logic [NBOOT_W-1:0]    run_nboot;
  logic                  uniform;
  logic [TOTAL_W-1:0]    expected_total;
  logic [TOTAL_W-1:0]    remaining_total;
  logic [NBOOT_W-1:0]    current_column;
  logic [IDX_W-1:0]      current_row;
  logic [IDX_W-1:0]      col_mod;
  logic [NBOOT_W-1:0]    col_base;
  logic [IDX_W-1:0]      omitted_index;
  logic [COUNT_BITS-1:0] omitted_count;
  logic                  omission_enabled;
  logic                  run_active;
  logic                  draws_begun;

  // Per-transaction working registers.
  bbid_in_t              cmd_q;
  logic [IDX_W-1:0]      sweep_idx;
  logic [TOTAL_W-1:0]    k_q;
  logic [TOTAL_W-1:0]    sum;
  logic [N_W-1:0]        issue_j;
  logic                  chk_valid;
  logic [IDX_W-1:0]      chk_j;
  logic                  found_hit;
  logic [IDX_W-1:0]      found_j;
  logic [COUNT_BITS-1:0] found_cnt;

  // RAM and multiplier connections.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  bbid_mul_req_t         mul_req;
  logic                  mul_done;
  logic [MUL_P_W-1:0]    mul_product;

  // Decisions shared by the next-state logic and the datapath.
  logic               accept;
  logic               wr_ok;
  logic               mismatch;
  logic               need_omit;
  logic               last_round;
  logic               collapse;
  logic [N_W-1:0]     n_minus1;
  logic [TOTAL_W-1:0] sum_new;
  logic               hit;
  logic               scan_end;
  logic               col_end;
  logic               run_end;

  bbid_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_SAMPLES)) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bbid_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_product)
  );

  assign busy   = (st != ST_IDLE);
  assign accept = start && !busy;

  // Condition terms.
  always_comb begin
    n_minus1   = run_n - 1'b1;
    wr_ok      = run_active && !draws_begun && ({1'b0, cmd.index} < run_n);
    mismatch   = !draws_begun && (remaining_total != expected_total);
    need_omit  = omission_enabled && (current_row == '0);
    last_round = (run_nboot - col_base) < NBOOT_W'(run_n);
    collapse   = omission_enabled && (remaining_total == TOTAL_W'(omitted_count));
    sum_new    = sum + TOTAL_W'(ram_rdata);
    hit        = chk_valid && (k_q < sum_new);
    scan_end   = chk_valid && ({1'b0, chk_j} == n_minus1);
    col_end    = ({1'b0, current_row} + 1'b1) == run_n;
    run_end    = ({1'b0, current_column} + 1'b1) == {1'b0, run_nboot};
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Next state, RAM ports and multiplier requests.
  always_comb begin
    st_next   = st;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    mul_req   = '0;
    unique case (st)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.action)
            ACT_START_UNIFORM, ACT_START_EMPTY: st_next = ST_SWEEP;
            ACT_WRITE_WEIGHT: st_next = wr_ok ? ST_WR_READ : ST_IDLE;
            ACT_DRAW: begin
              if (!run_active || mismatch) begin
                st_next = ST_IDLE;
              end else begin
                st_next = need_omit ? ST_OMIT_SEL : ST_COLLAPSE;
              end
            end
            default: st_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_idx;
        ram_wdata = uniform ? COUNT_BITS'(run_nboot) : '0;
        if ({1'b0, sweep_idx} == n_minus1) begin
          mul_req.go = 1'b1;
          mul_req.a  = RAND_W'(run_nboot);
          mul_req.b  = MUL_B_W'(run_n);
          st_next    = ST_EXP_MUL;
        end
      end
      ST_EXP_MUL: begin
        if (mul_done) begin
          st_next = ST_IDLE;
        end
      end
      ST_WR_READ: begin
        ram_raddr = cmd_q.index;
        st_next   = ST_WR_UPD;
      end
      ST_WR_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = cmd_q.index;
        ram_wdata = COUNT_BITS'(cmd_q.weight);
        st_next   = ST_IDLE;
      end
      ST_OMIT_SEL: begin
        if (last_round) begin
          mul_req.go = 1'b1;
          mul_req.a  = cmd_q.rand_omit;
          mul_req.b  = MUL_B_W'(run_n);
          st_next    = ST_OMIT_MUL;
        end else begin
          st_next = ST_OMIT_RD;
        end
      end
      ST_OMIT_MUL: begin
        if (mul_done) begin
          st_next = ST_OMIT_RD;
        end
      end
      ST_OMIT_RD: begin
        ram_raddr = omitted_index;
        st_next   = ST_OMIT_WR;
      end
      ST_OMIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = omitted_index;
        ram_wdata = '0;
        st_next   = ST_COLLAPSE;
      end
      ST_COLLAPSE: begin
        // Put the omitted count back when it is all that remains.
        if (collapse) begin
          ram_we    = 1'b1;
          ram_waddr = omitted_index;
          ram_wdata = omitted_count;
        end
        st_next = ST_DRAW_GO;
      end
      ST_DRAW_GO: begin
        mul_req.go = 1'b1;
        mul_req.a  = cmd_q.rand_draw;
        mul_req.b  = remaining_total - TOTAL_W'(omitted_count);
        st_next    = ST_DRAW_MUL;
      end
      ST_DRAW_MUL: begin
        if (mul_done) begin
          st_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_raddr = issue_j[IDX_W-1:0];
        if (hit) begin
          st_next = ST_DEC;
        end else if (scan_end) begin
          st_next = ST_FINISH;
        end
      end
      ST_DEC: begin
        if (run_nboot > NBOOT_W'(1)) begin
          ram_we    = 1'b1;
          ram_waddr = found_j;
          ram_wdata = found_cnt - 1'b1;
        end
        st_next = ST_FINISH;
      end
      ST_FINISH: begin
        // Restore the omitted index at the end of its column.
        if (col_end && omission_enabled) begin
          ram_we    = 1'b1;
          ram_waddr = omitted_index;
          ram_wdata = omitted_count;
        end
        st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= N_W'(1);
      resample_count <= NBOOT_W'(1);
      leave_one_out  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT:   sample_count   <= cfg_data[N_W-1:0];
        REG_RESAMPLE_COUNT: resample_count <= cfg_data[NBOOT_W-1:0];
        REG_LEAVE_ONE_OUT:  leave_one_out  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Run state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      run_n            <= '0;
      run_nboot        <= '0;
      uniform          <= 1'b0;
      expected_total   <= '0;
      remaining_total  <= '0;
      current_column   <= '0;
      current_row      <= '0;
      col_mod          <= '0;
      col_base         <= '0;
      omitted_index    <= '0;
      omitted_count    <= '0;
      omission_enabled <= 1'b0;
      run_active       <= 1'b0;
      draws_begun      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            case (cmd.action)
              ACT_START_UNIFORM, ACT_START_EMPTY: begin
                result <= '0;
                if (sample_count == '0) begin
                  run_n <= N_W'(1);
                end else if (sample_count > N_W'(MAX_SAMPLES)) begin
                  run_n <= N_W'(MAX_SAMPLES);
                end else begin
                  run_n <= sample_count;
                end
                run_nboot        <= (resample_count == '0) ? NBOOT_W'(1) : resample_count;
                uniform          <= (cmd.action == ACT_START_UNIFORM);
                current_column   <= '0;
                current_row      <= '0;
                col_mod          <= '0;
                col_base         <= '0;
                omitted_index    <= '0;
                omitted_count    <= '0;
                omission_enabled <= leave_one_out;
                run_active       <= 1'b1;
                draws_begun      <= 1'b0;
                sweep_idx        <= '0;
              end
              ACT_WRITE_WEIGHT: begin
                if (!wr_ok) begin
                  done   <= 1'b1;
                  result <= '{status: STAT_ACK, default: '0};
                end else begin
                  result <= '0;
                end
              end
              default: begin
                if (!run_active) begin
                  done   <= 1'b1;
                  result <= '{status: STAT_COMPLETE, default: '0};
                end else if (mismatch) begin
                  done       <= 1'b1;
                  result     <= '{status: STAT_MISMATCH, default: '0};
                  run_active <= 1'b0;
                end else begin
                  result      <= '0;
                  draws_begun <= 1'b1;
                end
              end
            endcase
          end
        end
        ST_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
        end
        ST_EXP_MUL: begin
          if (mul_done) begin
            expected_total  <= mul_product[TOTAL_W-1:0];
            remaining_total <= uniform ? mul_product[TOTAL_W-1:0] : '0;
            done            <= 1'b1;
            result.status   <= STAT_ACK;
          end
        end
        ST_WR_UPD: begin
          remaining_total <= remaining_total - TOTAL_W'(ram_rdata)
                           + TOTAL_W'(cmd_q.weight);
          done            <= 1'b1;
          result.status   <= STAT_ACK;
        end
        ST_OMIT_SEL: begin
          if (!last_round) begin
            omitted_index <= col_mod;
          end
        end
        ST_OMIT_MUL: begin
          if (mul_done) begin
            omitted_index <= mul_product[RAND_W +: IDX_W];
          end
        end
        ST_OMIT_WR: begin
          omitted_count <= ram_rdata;
        end
        ST_COLLAPSE: begin
          if (collapse) begin
            omitted_count    <= '0;
            omission_enabled <= 1'b0;
          end
        end
        ST_DRAW_MUL: begin
          if (mul_done) begin
            k_q       <= mul_product[RAND_W +: TOTAL_W];
            sum       <= '0;
            issue_j   <= '0;
            chk_valid <= 1'b0;
            found_hit <= 1'b0;
          end
        end
        ST_SCAN: begin
          // Read one count per cycle; check the one read the cycle before.
          chk_valid <= (issue_j < run_n);
          chk_j     <= issue_j[IDX_W-1:0];
          issue_j   <= issue_j + 1'b1;
          if (chk_valid) begin
            sum <= sum_new;
          end
          if (hit) begin
            found_hit <= 1'b1;
            found_j   <= chk_j;
            found_cnt <= ram_rdata;
          end
        end
        ST_DEC: begin
          if (run_nboot > NBOOT_W'(1)) begin
            remaining_total <= remaining_total - 1'b1;
          end
        end
        ST_FINISH: begin
          done                  <= 1'b1;
          result.status         <= STAT_SAMPLE;
          result.sample_index   <= found_hit ? ({1'b0, found_j} + 1'b1) : '0;
          result.column_number  <= current_column;
          result.row_number     <= current_row;
          result.last_in_column <= col_end;
          result.last_of_run    <= col_end && run_end;
          if (col_end) begin
            if (omission_enabled) begin
              omitted_count <= '0;
            end
            current_row    <= '0;
            current_column <= current_column + 1'b1;
            if ({1'b0, col_mod} == n_minus1) begin
              col_mod  <= '0;
              col_base <= col_base + NBOOT_W'(run_n);
            end else begin
              col_mod <= col_mod + 1'b1;
            end
            if (run_end) begin
              run_active <= 1'b0;
            end
          end else begin
            current_row <= current_row + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while the sequencer is busy");

  // An accepted command either starts work or answers at once.
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither started nor answered");

  // Only a delivered sample carries index and position fields.
  a_status_fields: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STAT_SAMPLE) |->
      (result.sample_index == '0 && result.column_number == '0 &&
       result.row_number == '0 && !result.last_in_column && !result.last_of_run))
    else $error("non-sample result with nonzero fields");

  // The scan never checks beyond the last index in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SCAN && chk_valid) |-> ({1'b0, chk_j} < run_n))
    else $error("scan ran past the sample count");

endmodule

`default_nettype wire
